[rtl/mp_nlri_attribute_parser_top_macros.svh]
// assertion helpers used by mp_nlri_back
`ifndef MP_NLRI_ATTRIBUTE_PARSER_TOP_MACROS_SVH
`define MP_NLRI_ATTRIBUTE_PARSER_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define MP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the following cycle
`define MP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mp_nlri_pkg.sv]
// ----------------------------------------------------------------------------
// mp_nlri_pkg
// types and constants shared by the attribute parser modules
// ----------------------------------------------------------------------------
package mp_nlri_pkg;

  localparam int unsigned MaxPrefixes = 4095;
  localparam int unsigned AddrBytes   = 16;
  localparam int unsigned MaxPfxBits  = AddrBytes * 8;
  localparam int unsigned QDepth      = 4;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadFamily = 3'd1;
  localparam logic [2:0] StBadSub    = 3'd2;
  localparam logic [2:0] StNhLen     = 3'd3;
  localparam logic [2:0] StPfxLen    = 3'd4;
  localparam logic [2:0] StTrunc     = 3'd5;

  localparam logic [0:0] CfgFamily    = 1'b0;
  localparam logic [0:0] CfgSubfamily = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       withdraw;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic        withdrawn;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  prefix_length;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [2:0]  status;
    logic [11:0] prefix_total;
    logic        end_of_run;
  } out_req_t;

  // classified command from front to back
  typedef struct packed {
    logic        has_pfx;
    logic        has_sum;
    logic        withdrawn;
    logic [63:0] pfx_high;
    logic [63:0] pfx_low;
    logic [7:0]  pfx_len;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [2:0]  status;
    logic [11:0] total;
  } cmd_t;

  function automatic logic [63:0] upper_mask(input logic [7:0] len);
    logic [63:0] m;
    if (len == 8'd0) m = '0;
    else if (len >= 8'd64) m = '1;
    else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> len[5:0]);
    return m;
  endfunction

  function automatic logic [63:0] lower_mask(input logic [7:0] len);
    logic [63:0] m;
    logic [7:0]  r;
    r = len - 8'd64;
    if (len <= 8'd64) m = '0;
    else if (len >= 8'd128) m = '1;
    else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> r[5:0]);
    return m;
  endfunction

endpackage

[rtl/mp_nlri_front.sv]
// ----------------------------------------------------------------------------
// mp_nlri_front
// byte parser: walks the attribute and turns each byte that ends a prefix or the attribute into a command
// ----------------------------------------------------------------------------
module mp_nlri_front import mp_nlri_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_req_t     req,
  input  logic [15:0] acc_family,
  input  logic [7:0]  acc_subfamily,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_AFI_HI, PH_AFI_LO, PH_SAFI, PH_NH_LEN, PH_NH, PH_SNPA_CNT,
    PH_SNPA_LEN, PH_SNPA_SKIP, PH_PFX_LEN, PH_PFX_BYTES, PH_DISCARD
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [4:0]  idx_r, idx_nxt, idx;
  logic [15:0] fam_r, fam_nxt, fam;
  logic [63:0] hoph_r, hoph_nxt, hoph, hopl_r, hopl_nxt, hopl;
  logic [7:0]  snpa_r, snpa_nxt, snpa, skip_r, skip_nxt, skip;
  logic [7:0]  clen_r, clen_nxt, clen;
  logic [63:0] pfh_r, pfh_nxt, pfh, pfl_r, pfl_nxt, pfl;
  logic [4:0]  pleft_r, pleft_nxt, pleft;
  logic [11:0] cnt_r, cnt_nxt, cnt;
  logic [2:0]  err_r, err_nxt, err;
  logic        wd_r, wd_nxt, wd;
  logic        emit_p;
  logic [7:0]  b;
  logic [8:0]  half;
  logic [63:0] sh;
  logic [2:0]  st;

  always_comb begin
    b    = req.data_byte;
    ph   = phase_r; idx = idx_r; fam = fam_r; hoph = hoph_r; hopl = hopl_r;
    snpa = snpa_r; skip = skip_r; clen = clen_r; pfh = pfh_r; pfl = pfl_r;
    pleft = pleft_r; cnt = cnt_r; err = err_r; wd = wd_r;
    emit_p = 1'b0;
    half = ({1'b0, b} + 9'd1) >> 1;
    sh = {56'd0, b} << (6'd56 - {idx[2:0], 3'd0});
    if (req.first_byte) begin
      ph = PH_AFI_HI; idx = '0; fam = '0; hoph = '0; hopl = '0; snpa = '0;
      skip = '0; clen = '0; pfh = '0; pfl = '0; pleft = '0; cnt = '0;
      err = StOk; wd = req.withdraw;
      sh = {b, 56'd0};
    end
    case (ph)
      PH_AFI_HI: begin fam = {b, 8'd0}; ph = PH_AFI_LO; end
      PH_AFI_LO: begin fam = fam | {8'd0, b}; ph = PH_SAFI; end
      PH_SAFI: begin
        if (fam != acc_family) begin err = StBadFamily; ph = PH_DISCARD; end
        else if (b != acc_subfamily) begin err = StBadSub; ph = PH_DISCARD; end
        else ph = wd ? PH_PFX_LEN : PH_NH_LEN;
      end
      PH_NH_LEN: begin
        if (b != 8'(AddrBytes)) begin err = StNhLen; ph = PH_DISCARD; end
        else begin idx = '0; ph = PH_NH; end
      end
      PH_NH: begin
        if (!idx[3]) hoph = hoph | sh;
        else hopl = hopl | sh;
        idx = idx + 5'd1;
        if (idx >= 5'(AddrBytes)) ph = PH_SNPA_CNT;
      end
      PH_SNPA_CNT: begin
        snpa = b;
        ph = (b == 8'd0) ? PH_PFX_LEN : PH_SNPA_LEN;
      end
      PH_SNPA_LEN: begin
        skip = half[7:0];
        if (skip == 8'd0) begin
          snpa = snpa - 8'd1;
          ph = (snpa == 8'd0) ? PH_PFX_LEN : PH_SNPA_LEN;
        end else ph = PH_SNPA_SKIP;
      end
      PH_SNPA_SKIP: begin
        skip = skip - 8'd1;
        if (skip == 8'd0) begin
          snpa = snpa - 8'd1;
          ph = (snpa == 8'd0) ? PH_PFX_LEN : PH_SNPA_LEN;
        end
      end
      PH_PFX_LEN: begin
        if (b > 8'(MaxPfxBits)) begin err = StPfxLen; ph = PH_DISCARD; end
        else begin
          clen = b; pfh = '0; pfl = '0; idx = '0;
          pleft = 5'((9'(b) + 9'd7) >> 3);
          if (pleft == 5'd0) emit_p = 1'b1;
          else ph = PH_PFX_BYTES;
        end
      end
      PH_PFX_BYTES: begin
        if (!idx[3]) pfh = pfh | sh;
        else pfl = pfl | sh;
        idx = idx + 5'd1;
        pleft = pleft - 5'd1;
        if (pleft == 5'd0) emit_p = 1'b1;
      end
      default: ;
    endcase
    if (emit_p) begin
      if (cnt < 12'(MaxPrefixes)) cnt = cnt + 12'd1;
      ph = PH_PFX_LEN;
    end
    st = err;
    if (st == StOk && ph != PH_PFX_LEN) st = StTrunc;
    cmd.has_pfx   = emit_p;
    cmd.has_sum   = req.last_byte && (phase_r != PH_IDLE || req.first_byte);
    cmd.withdrawn = wd;
    cmd.pfx_high  = pfh & upper_mask(clen);
    cmd.pfx_low   = pfl & lower_mask(clen);
    cmd.pfx_len   = clen;
    cmd.hop_high  = hoph;
    cmd.hop_low   = hopl;
    cmd.status    = st;
    cmd.total     = cnt;
    cmd_valid     = step && (cmd.has_pfx || cmd.has_sum);
    if (cmd.has_sum) ph = PH_IDLE;
    phase_nxt = ph; idx_nxt = idx; fam_nxt = fam; hoph_nxt = hoph; hopl_nxt = hopl;
    snpa_nxt = snpa; skip_nxt = skip; clen_nxt = clen; pfh_nxt = pfh; pfl_nxt = pfl;
    pleft_nxt = pleft; cnt_nxt = cnt; err_nxt = err; wd_nxt = wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; idx_r <= '0; fam_r <= '0; hoph_r <= '0; hopl_r <= '0;
      snpa_r <= '0; skip_r <= '0; clen_r <= '0; pfh_r <= '0; pfl_r <= '0;
      pleft_r <= '0; cnt_r <= '0; err_r <= '0; wd_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; fam_r <= fam_nxt;
      hoph_r <= hoph_nxt; hopl_r <= hopl_nxt; snpa_r <= snpa_nxt;
      skip_r <= skip_nxt; clen_r <= clen_nxt; pfh_r <= pfh_nxt; pfl_r <= pfl_nxt;
      pleft_r <= pleft_nxt; cnt_r <= cnt_nxt; err_r <= err_nxt; wd_r <= wd_nxt;
    end
  end

endmodule

[rtl/mp_nlri_back.sv]
// ----------------------------------------------------------------------------
// mp_nlri_back
// command queue and result sequencer: splits each command into records
// ----------------------------------------------------------------------------
`include "mp_nlri_attribute_parser_top_macros.svh"
module mp_nlri_back import mp_nlri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cmd_t     cmd,
  output logic     full,
  output logic     out_valid,
  output out_req_t out_data,
  input  logic     out_stall
);

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic            pdone_r;
  logic            pop, take, empty;
  cmd_t            head;

  assign empty = (cnt_r == '0);
  // room kept so the front never needs to look at the pop
  assign full  = (cnt_r >= (PtrW+1)'(QDepth - 1));
  assign head  = q_mem[rp_r];
  assign take  = out_valid && !out_stall;
  assign pop   = take && (!head.has_pfx || pdone_r || !head.has_sum);

  always_comb begin
    out_valid = !empty;
    if (head.has_pfx && !pdone_r) begin
      out_data.result_kind   = 1'b0;
      out_data.withdrawn     = head.withdrawn;
      out_data.prefix_high   = head.pfx_high;
      out_data.prefix_low    = head.pfx_low;
      out_data.prefix_length = head.pfx_len;
      out_data.hop_high      = head.hop_high;
      out_data.hop_low       = head.hop_low;
      out_data.status        = StOk;
      out_data.prefix_total  = head.total;
      out_data.end_of_run    = !head.has_sum;
    end else begin
      out_data.result_kind   = 1'b1;
      out_data.withdrawn     = head.withdrawn;
      out_data.prefix_high   = '0;
      out_data.prefix_low    = '0;
      out_data.prefix_length = '0;
      out_data.hop_high      = '0;
      out_data.hop_low       = '0;
      out_data.status        = head.status;
      out_data.prefix_total  = head.total;
      out_data.end_of_run    = 1'b1;
    end
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; pdone_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (pop) rp_r <= rp_r + PtrW'(1);
      cnt_r <= cnt_nxt;
      if (pop) pdone_r <= 1'b0;
      else if (take) pdone_r <= 1'b1;
    end
  end

  `MP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_r < (PtrW+1)'(QDepth))
  `MP_ASSERT_IMP(a_pdone_only_pair, clk, rst_n, pdone_r && !empty,
                 head.has_pfx && head.has_sum)
  `MP_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_data))

endmodule

[rtl/mp_nlri_attribute_parser_top.sv]
// a command is registered in the queue when its byte is taken and leaves from the queue head
// throughput: one attribute byte per cycle unless in_stall; records drain one per cycle unless out_stall
// a byte that yields a prefix and a summary gives a prefix record, then a summary record
// the front stalls only when the four-entry command queue is nearly full
// reset (rst_n low, synchronous) returns the parser to idle, empties the
// queue and sets accepted family 2 and subfamily 1
// ----------------------------------------------------------------------------
// mp_nlri_attribute_parser_top
// multiprotocol reach/unreach attribute parser, one byte per request
// ----------------------------------------------------------------------------
module mp_nlri_attribute_parser_top import mp_nlri_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] fam_r;
  logic [7:0]  sub_r;
  logic        full, step, cmd_valid;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign step      = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fam_r <= 16'd2;
      sub_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgFamily:    fam_r <= cfg_data;
        CfgSubfamily: sub_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mp_nlri_front u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .req(in_data),
    .acc_family(fam_r), .acc_subfamily(sub_r),
    .cmd_valid(cmd_valid), .cmd(cmd)
  );

  mp_nlri_back u_back (
    .clk(clk), .rst_n(rst_n), .push(cmd_valid), .cmd(cmd), .full(full),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

endmodule

[test/tb_mp_nlri_attribute_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_mp_nlri_attribute_parser_top
// drives multiprotocol reach/unreach attribute bytes into the parser, predicts
// every prefix and summary record, and compares each field of the output
// ----------------------------------------------------------------------------
module tb_mp_nlri_attribute_parser_top;
  import mp_nlri_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_AFI_HI, P_AFI_LO, P_SAFI, P_NH_LEN, P_NH, P_SNPA_CNT,
    P_SNPA_LEN, P_SNPA_SKIP, P_PFX_LEN, P_PFX_BYTES, P_DISCARD
  } phase_e;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  mp_nlri_attribute_parser_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // predictor state
  logic [15:0] fam_cfg;
  logic [7:0]  sub_cfg;
  phase_e      phase;
  logic [4:0]  byte_idx;
  logic [15:0] family;
  logic [63:0] hop_hi, hop_lo, pfx_hi, pfx_lo;
  logic [7:0]  snpa_cnt, skip_cnt, pfx_len;
  logic [4:0]  pfx_left;
  logic [11:0] pfx_count;
  logic [2:0]  err;
  logic        wd;

  in_req_t  byte_queue[$];
  out_req_t record_queue[$];
  int  errors = 0;
  bit  feed_done = 0;
  bit  no_idle = 0;
  bit  hold_sender = 0;
  int  long_hold = 0;
  bit  in_acc = 0;

  function automatic logic [63:0] hi_mask(input logic [7:0] len);
    if (len == 0) return '0;
    if (len >= 64) return '1;
    return ~64'd0 << (64 - len);
  endfunction

  function automatic logic [63:0] lo_mask(input logic [7:0] len);
    if (len <= 64) return '0;
    if (len >= 128) return '1;
    return ~64'd0 << (128 - len);
  endfunction

  task automatic put_byte(inout logic [63:0] hi, inout logic [63:0] lo,
                          input logic [4:0] idx, input logic [7:0] b);
    logic [3:0] i;
    i = idx[3:0];
    if (i < 8) hi = hi | (64'(b) << (56 - 8 * i));
    else lo = lo | (64'(b) << (56 - 8 * (i - 8)));
  endtask

  task automatic push_record(input logic kind, input logic [63:0] ph,
                             input logic [63:0] pl, input logic [7:0] plen,
                             input logic [63:0] hh, input logic [63:0] hl,
                             input logic [2:0] st);
    out_req_t r;
    r.result_kind = kind;
    r.withdrawn = wd;
    r.prefix_high = ph;
    r.prefix_low = pl;
    r.prefix_length = plen;
    r.hop_high = hh;
    r.hop_low = hl;
    r.status = st;
    r.prefix_total = pfx_count;
    r.end_of_run = 1'b0;
    record_queue.push_back(r);
  endtask

  task automatic emit_prefix();
    if (pfx_count < MaxPrefixes) pfx_count++;
    push_record(1'b0, pfx_hi & hi_mask(pfx_len), pfx_lo & lo_mask(pfx_len),
                pfx_len, hop_hi, hop_lo, StOk);
    phase = P_PFX_LEN;
  endtask

  task automatic snpa_entry_done();
    snpa_cnt = snpa_cnt - 1;
    phase = (snpa_cnt == 0) ? P_PFX_LEN : P_SNPA_LEN;
  endtask

  task automatic predict_byte(input in_req_t it);
    logic [7:0] b;
    logic [2:0] st;
    int n;
    b = it.data_byte;
    n = 0;
    if (it.first_byte) begin
      phase = P_AFI_HI; byte_idx = 0; family = 0; hop_hi = 0; hop_lo = 0;
      snpa_cnt = 0; skip_cnt = 0; pfx_len = 0; pfx_hi = 0; pfx_lo = 0;
      pfx_left = 0; pfx_count = 0; err = StOk; wd = it.withdraw;
    end
    if (phase == P_IDLE) return;
    n = record_queue.size();
    case (phase)
      P_AFI_HI: begin family = {b, 8'd0}; phase = P_AFI_LO; end
      P_AFI_LO: begin family[7:0] = b; phase = P_SAFI; end
      P_SAFI: begin
        if (family != fam_cfg) begin err = StBadFamily; phase = P_DISCARD; end
        else if (b != sub_cfg) begin err = StBadSub; phase = P_DISCARD; end
        else phase = wd ? P_PFX_LEN : P_NH_LEN;
      end
      P_NH_LEN: begin
        if (b != AddrBytes) begin err = StNhLen; phase = P_DISCARD; end
        else begin byte_idx = 0; phase = P_NH; end
      end
      P_NH: begin
        put_byte(hop_hi, hop_lo, byte_idx, b);
        byte_idx++;
        if (byte_idx >= AddrBytes) phase = P_SNPA_CNT;
      end
      P_SNPA_CNT: begin
        snpa_cnt = b;
        phase = (b == 0) ? P_PFX_LEN : P_SNPA_LEN;
      end
      P_SNPA_LEN: begin
        skip_cnt = 8'((9'(b) + 9'd1) >> 1);
        if (skip_cnt == 0) snpa_entry_done();
        else phase = P_SNPA_SKIP;
      end
      P_SNPA_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 0) snpa_entry_done();
      end
      P_PFX_LEN: begin
        if (b > MaxPfxBits) begin
          err = StPfxLen; phase = P_DISCARD;
        end else begin
          pfx_len = b; pfx_hi = 0; pfx_lo = 0; byte_idx = 0;
          pfx_left = 5'((b + 7) / 8);
          if (pfx_left == 0) emit_prefix();
          else phase = P_PFX_BYTES;
        end
      end
      P_PFX_BYTES: begin
        put_byte(pfx_hi, pfx_lo, byte_idx, b);
        byte_idx++;
        pfx_left--;
        if (pfx_left == 0) emit_prefix();
      end
      default: ;
    endcase
    if (it.last_byte) begin
      st = err;
      if (st == StOk && phase != P_PFX_LEN) st = StTrunc;
      push_record(1'b1, '0, '0, '0, '0, '0, st);
      phase = P_IDLE;
    end
    if (record_queue.size() > n) record_queue[$].end_of_run = 1'b1;
  endtask

  // request taken at the last rising edge
  always @(posedge clk) in_acc <= rst_n && in_valid && !in_stall;

  // driver: one pending byte per cycle unless in_stall, with idle bursts
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (in_acc || !in_valid)) begin
      if (in_acc) predict_byte(in_data);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0 && !hold_sender) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_req_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (record_queue.size() == 0) begin
        $error("unexpected record %p", out_data);
        errors++;
      end else begin
        exp_r = record_queue.pop_front();
        if (out_data.result_kind !== exp_r.result_kind) begin
          $error("result_kind exp %0h got %0h", exp_r.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.withdrawn !== exp_r.withdrawn) begin
          $error("withdrawn exp %0h got %0h", exp_r.withdrawn, out_data.withdrawn);
          errors++;
        end
        if (out_data.prefix_high !== exp_r.prefix_high) begin
          $error("prefix_high exp %0h got %0h", exp_r.prefix_high, out_data.prefix_high);
          errors++;
        end
        if (out_data.prefix_low !== exp_r.prefix_low) begin
          $error("prefix_low exp %0h got %0h", exp_r.prefix_low, out_data.prefix_low);
          errors++;
        end
        if (out_data.prefix_length !== exp_r.prefix_length) begin
          $error("prefix_length exp %0d got %0d", exp_r.prefix_length,
                 out_data.prefix_length);
          errors++;
        end
        if (out_data.hop_high !== exp_r.hop_high) begin
          $error("hop_high exp %0h got %0h", exp_r.hop_high, out_data.hop_high);
          errors++;
        end
        if (out_data.hop_low !== exp_r.hop_low) begin
          $error("hop_low exp %0h got %0h", exp_r.hop_low, out_data.hop_low);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.prefix_total !== exp_r.prefix_total) begin
          $error("prefix_total exp %0d got %0d", exp_r.prefix_total,
                 out_data.prefix_total);
          errors++;
        end
        if (out_data.end_of_run !== exp_r.end_of_run) begin
          $error("end_of_run exp %0h got %0h", exp_r.end_of_run, out_data.end_of_run);
          errors++;
        end
      end
    end
  end

  task automatic add(input logic [7:0] b, input bit f = 0, input bit l = 0,
                     input bit w = 0);
    in_req_t it;
    it.data_byte = b;
    it.first_byte = f;
    it.last_byte = l;
    it.withdraw = w;
    byte_queue.push_back(it);
  endtask

  // one attribute; fault picks a defect, fault 5 cuts it short
  task automatic add_attribute(input bit w, input int npfx, input int fault,
                               input int max_len);
    logic [7:0] hdr[$];
    logic [7:0] len;
    int k, m;
    hdr.push_back(fault == 1 ? ~fam_cfg[15:8] : fam_cfg[15:8]);
    hdr.push_back(fam_cfg[7:0]);
    hdr.push_back(fault == 2 ? ~sub_cfg : sub_cfg);
    if (!w) begin
      hdr.push_back(fault == 3 ? 8'($urandom_range(0, 255)) | 8'h20 : 8'd16);
      for (k = 0; k < 16; k++) hdr.push_back(8'($urandom));
      m = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
      hdr.push_back(8'(m));
      for (k = 0; k < m; k++) begin
        len = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 9));
        hdr.push_back(len);
        for (int j = 0; j < (len + 1) / 2; j++) hdr.push_back(8'($urandom));
      end
    end
    for (k = 0; k < npfx; k++) begin
      len = $urandom_range(0, max_len);
      if (fault == 4 && k == npfx - 1) len = $urandom_range(129, 255);
      hdr.push_back(len);
      if (len <= 128)
        for (int j = 0; j < (len + 7) / 8; j++) hdr.push_back(8'($urandom));
    end
    if (fault == 5 && hdr.size() > 1) hdr = hdr[0:$urandom_range(0, hdr.size() - 2)];
    for (k = 0; k < hdr.size(); k++) add(hdr[k], k == 0, k == hdr.size() - 1, w);
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || in_valid || record_queue.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgFamily) fam_cfg = v;
    else sub_cfg = v[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int nbytes, input int max_len);
    int start;
    start = byte_queue.size();
    while (byte_queue.size() - start < nbytes) begin
      case ($urandom_range(0, 19))
        0: add_attribute($urandom_range(0, 1), 3, $urandom_range(1, 5), max_len);
        1: add(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        default: add_attribute($urandom_range(0, 1), $urandom_range(0, 4),
                               $urandom_range(0, 5) == 0 ? 5 : 0, max_len);
      endcase
    end
  endtask

  initial begin
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CfgFamily;
    cfg_data = '0;
    fam_cfg = 16'd2;
    sub_cfg = 8'd1;
    phase = P_IDLE;
    {byte_idx, family, hop_hi, hop_lo, snpa_cnt, skip_cnt, pfx_len} = '0;
    {pfx_hi, pfx_lo, pfx_left, pfx_count, err, wd} = '0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: stray bytes, each status, extremes of lengths
    add(8'hFF, 0, 1, 1);
    add(8'h00, 0, 0, 0);
    add(8'h00, 1, 0, 0); add(8'h02, 0, 0, 0); add(8'h01, 0, 0, 0); // restart mid
    add(8'h00, 1, 0, 1); add(8'h02); add(8'h01); add(8'd0);
    add(8'd128); for (int k = 0; k < 16; k++) add(8'hFF, 0, k == 15);
    add_attribute(1, 2, 4, 128);
    add_attribute(0, 2, 1, 128);
    add_attribute(0, 1, 2, 128);
    wait_drained();
    add_attribute(0, 1, 3, 128);
    add_attribute(0, 3, 0, 128);
    add(8'h00, 1, 0, 1); add(8'h02); add(8'h01); add(8'd129, 0, 1);
    add(8'h00, 1, 1, 0);
    wait_drained();

    random_phase(200, 128);
    wait_drained();
    write_reg(CfgFamily, 16'hFFFF);
    write_reg(CfgSubfamily, 16'h00FF);
    random_phase(300, 40);
    // long receiver hold while bytes keep coming
    long_hold = 60;
    wait_drained();
    write_reg(CfgFamily, 16'h0000);
    write_reg(CfgSubfamily, 16'h0000);
    random_phase(300, 128);
    wait_drained();
    write_reg(CfgFamily, 16'(($urandom)));
    write_reg(CfgSubfamily, 16'($urandom_range(0, 255)));
    random_phase(300, 128);
    wait_drained();
    write_reg(CfgFamily, 16'd2);
    write_reg(CfgSubfamily, 16'd1);
    no_idle = 1;
    random_phase(250, 128);
    feed_done = 1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && record_queue.size() == 0)
      $display("tb_mp_nlri_attribute_parser_top: done, clean");
    else
      $display("tb_mp_nlri_attribute_parser_top: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_mp_nlri_attribute_parser_top: done, errors");
    $finish;
  end

endmodule
